/* rtl/assert_macros.svh */
// Assertion macros used by the interval tracker datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset.
`define DIT_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

/* rtl/dit_pkg.sv */
// Shared types, codes and defaults of the disjoint interval tracker.
package dit_pkg;

    localparam int FIELD_W        = 31;
    localparam int STATUS_W       = 3;
    localparam int S_DATA_W       = 32;
    localparam int M_DATA_W       = 64;
    localparam int DEF_MAX_RANGES = 16;
    localparam int DEF_VALUE_BITS = 31;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_LISTED    = 3'd3,
        ST_NONE      = 3'd4
    } dit_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DN_RD,
        S_DN_WR,
        S_UP_RD,
        S_UP_WR,
        S_LIST,
        S_DONE
    } dit_state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_START,
        OP_SCAN_NEXT,
        OP_SCAN_END,
        OP_MERGE,
        OP_EXT_LOW,
        OP_EXT_HIGH,
        OP_UP_SETUP,
        OP_DN_RD,
        OP_DN_WR,
        OP_UP_RD,
        OP_UP_WR,
        OP_INSERT,
        OP_EMIT_LIST,
        OP_EMIT_CODE
    } dit_op_t;

    typedef struct packed {
        dit_op_t     op;
        dit_status_t code;
    } dit_cmd_t;

    typedef struct packed {
        logic req_list;
        logic count_zero;
        logic scan_hit;
        logic dup;
        logic join_low;
        logic join_high;
        logic full;
        logic dn_more;
        logic up_more;
        logic list_last;
        logic out_free;
    } dit_stat_t;

endpackage

/* rtl/disjoint_interval_tracker.sv */
// Top level of the disjoint interval tracker.
//
// Slave channel: s_tuser selects the request (0 add, 1 list), s_tdata holds the value.
// Master channel: s_tuser-style kind in m_tuser (status code), interval bounds in
// m_tdata, m_tlast on the final result of each request.
// One request is worked on at a time; s_tready is high only while the sequencer idles.
// Add: a scan up to the insert slot p, a decide step, then on a merge or an insert a
// read and a write per table entry moved, one closing step and a load of the result.
// List: one result per cycle while the result register is free; the rate is set by
// the single read port of the interval table RAM.
// A held result sits in the output register; the next request is taken meanwhile
// and waits only when it has a result to load while m_tready stays low.
// Reset empties the table at once through the count; the RAM needs no clearing pass.
module disjoint_interval_tracker #(
    parameter int MAX_RANGES = dit_pkg::DEF_MAX_RANGES,
    parameter int VALUE_BITS = dit_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dit_pkg::S_DATA_W-1:0]  s_tdata,  // value[30:0], zero pad
    input  logic                          s_tuser,  // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dit_pkg::M_DATA_W-1:0]  m_tdata,  // interval_low[30:0], interval_high[61:31]
    output logic [dit_pkg::STATUS_W-1:0]  m_tuser,  // status
    output logic                          m_tlast   // last
);

    import dit_pkg::*;

    dit_cmd_t  cmd;
    dit_stat_t stat;

    dit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dit_datapath #(
        .MAX_RANGES (MAX_RANGES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/dit_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dit_ctrl.sv */
// Sequencer of the interval tracker: scan, merge, shift, insert and list steps.
module dit_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dit_pkg::dit_stat_t stat,
    output dit_pkg::dit_cmd_t  cmd
);

    import dit_pkg::*;

    dit_state_t  state_reg, state_next;
    dit_status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_ADDED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!stat.req_list)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (stat.count_zero)
                    begin
                        code_next  = ST_NONE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LIST;
                    end
                end
            end
            S_SCAN:
            begin
                if (!stat.scan_hit)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                code_next = ST_ADDED;
                if (stat.dup)
                begin
                    code_next  = ST_DUPLICATE;
                    state_next = S_DONE;
                end
                else if (stat.join_low && stat.join_high)
                begin
                    state_next = S_DN_RD;
                end
                else if (stat.join_low || stat.join_high)
                begin
                    state_next = S_DONE;
                end
                else if (stat.full)
                begin
                    code_next  = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end
            S_DN_RD:
            begin
                state_next = stat.dn_more ? S_DN_WR : S_DONE;
            end
            S_DN_WR:
            begin
                state_next = S_DN_RD;
            end
            S_UP_RD:
            begin
                state_next = stat.up_more ? S_UP_WR : S_DONE;
            end
            S_UP_WR:
            begin
                state_next = S_UP_RD;
            end
            S_LIST:
            begin
                if (stat.out_free && stat.list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_IDLE;
        cmd.code = code_reg;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = OP_START;
                end
            end
            S_SCAN:
            begin
                cmd.op = stat.scan_hit ? OP_SCAN_NEXT : OP_SCAN_END;
            end
            S_DECIDE:
            begin
                if (stat.dup)
                begin
                    cmd.op = OP_IDLE;
                end
                else if (stat.join_low && stat.join_high)
                begin
                    cmd.op = OP_MERGE;
                end
                else if (stat.join_low)
                begin
                    cmd.op = OP_EXT_LOW;
                end
                else if (stat.join_high)
                begin
                    cmd.op = OP_EXT_HIGH;
                end
                else if (!stat.full)
                begin
                    cmd.op = OP_UP_SETUP;
                end
            end
            S_DN_RD:
            begin
                if (stat.dn_more)
                begin
                    cmd.op = OP_DN_RD;
                end
            end
            S_DN_WR:
            begin
                cmd.op = OP_DN_WR;
            end
            S_UP_RD:
            begin
                cmd.op = stat.up_more ? OP_UP_RD : OP_INSERT;
            end
            S_UP_WR:
            begin
                cmd.op = OP_UP_WR;
            end
            S_LIST:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_EMIT_LIST;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_EMIT_CODE;
                end
            end
            default:
            begin
                cmd.op = OP_IDLE;
            end
        endcase
    end

endmodule

/* rtl/dit_datapath.sv */
// Datapath of the interval tracker: interval table, scan registers, result register.
`include "assert_macros.svh"

module dit_datapath #(
    parameter int MAX_RANGES = dit_pkg::DEF_MAX_RANGES,
    parameter int VALUE_BITS = dit_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dit_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  dit_pkg::dit_cmd_t             cmd,
    output dit_pkg::dit_stat_t            stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dit_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [dit_pkg::STATUS_W-1:0]  m_tuser,
    output logic                          m_tlast
);

    import dit_pkg::*;

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int EXT_W = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int ENT_W = 2 * VALUE_BITS;
    localparam logic [VALUE_BITS-1:0] VMAX    = '1;
    localparam logic [CNT_W-1:0]      MAX_CNT = CNT_W'(MAX_RANGES);

    logic [VALUE_BITS-1:0] v_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      p_reg;
    logic [CNT_W-1:0]      j_reg;
    logic [VALUE_BITS-1:0] prev_start_reg, prev_end_reg;
    logic [VALUE_BITS-1:0] cur_start_reg, cur_end_reg;
    logic                  out_valid_reg;
    dit_status_t           out_status_reg;
    logic [FIELD_W-1:0]    out_low_reg, out_high_reg;
    logic                  out_last_reg;

    logic [EXT_W-1:0]      v_ext, lo_ext, hi_ext;
    logic [VALUE_BITS-1:0] v_in;
    logic [VALUE_BITS-1:0] rd_start, rd_end;
    logic [CNT_W-1:0]      idx_plus1, p_minus1, j_plus1, j_minus1;
    logic                  wr_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [ENT_W-1:0]      wr_data, rd_data;
    logic                  load_out;

    assign v_ext     = EXT_W'(s_tdata[FIELD_W-1:0]);
    assign v_in      = v_ext[VALUE_BITS-1:0];
    assign rd_start  = rd_data[ENT_W-1:VALUE_BITS];
    assign rd_end    = rd_data[VALUE_BITS-1:0];
    assign lo_ext    = EXT_W'(rd_start);
    assign hi_ext    = EXT_W'(rd_end);
    assign idx_plus1 = idx_reg + 1'b1;
    assign p_minus1  = p_reg - 1'b1;
    assign j_plus1   = j_reg + 1'b1;
    assign j_minus1  = j_reg - 1'b1;
    assign load_out  = (cmd.op == OP_EMIT_LIST) || (cmd.op == OP_EMIT_CODE);

    dit_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = j_reg[IDX_W-1:0];
        wr_data = rd_data;
        case (cmd.op)
            OP_START:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_SCAN_NEXT, OP_EMIT_LIST:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_plus1[IDX_W-1:0];
            end
            OP_MERGE:
            begin
                wr_en   = 1'b1;
                wr_addr = p_minus1[IDX_W-1:0];
                wr_data = {prev_start_reg, cur_end_reg};
            end
            OP_EXT_LOW:
            begin
                wr_en   = 1'b1;
                wr_addr = p_minus1[IDX_W-1:0];
                wr_data = {prev_start_reg, v_reg};
            end
            OP_EXT_HIGH:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg[IDX_W-1:0];
                wr_data = {v_reg, cur_end_reg};
            end
            OP_DN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = j_plus1[IDX_W-1:0];
            end
            OP_UP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = j_minus1[IDX_W-1:0];
            end
            OP_DN_WR, OP_UP_WR:
            begin
                wr_en = 1'b1;
            end
            OP_INSERT:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg[IDX_W-1:0];
                wr_data = {v_reg, v_reg};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            p_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_START:     idx_reg   <= '0;
                OP_SCAN_NEXT: idx_reg   <= idx_plus1;
                OP_SCAN_END:  p_reg     <= idx_reg;
                OP_MERGE:
                begin
                    count_reg <= count_reg - 1'b1;
                    j_reg     <= p_reg;
                end
                OP_UP_SETUP:  j_reg     <= count_reg;
                OP_DN_WR:     j_reg     <= j_plus1;
                OP_UP_WR:     j_reg     <= j_minus1;
                OP_INSERT:    count_reg <= count_reg + 1'b1;
                OP_EMIT_LIST: idx_reg   <= idx_plus1;
                default:      j_reg     <= j_reg;
            endcase
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_START)
        begin
            v_reg <= v_in;
        end
        if (cmd.op == OP_SCAN_NEXT)
        begin
            prev_start_reg <= rd_start;
            prev_end_reg   <= rd_end;
        end
        if (cmd.op == OP_SCAN_END)
        begin
            cur_start_reg <= rd_start;
            cur_end_reg   <= rd_end;
        end
        if (cmd.op == OP_EMIT_LIST)
        begin
            out_status_reg <= ST_LISTED;
            out_low_reg    <= lo_ext[FIELD_W-1:0];
            out_high_reg   <= hi_ext[FIELD_W-1:0];
            out_last_reg   <= (idx_plus1 == count_reg);
        end
        else if (cmd.op == OP_EMIT_CODE)
        begin
            out_status_reg <= cmd.code;
            out_low_reg    <= '0;
            out_high_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    always_comb
    begin
        stat.req_list   = s_tuser;
        stat.count_zero = (count_reg == '0);
        stat.scan_hit   = (idx_reg < count_reg) && (rd_start <= v_reg);
        stat.dup        = (p_reg != '0) && (prev_end_reg >= v_reg);
        stat.join_low   = (p_reg != '0) && (v_reg != '0)
                          && (prev_end_reg == v_reg - 1'b1);
        stat.join_high  = (p_reg < count_reg) && (v_reg != VMAX)
                          && (cur_start_reg == v_reg + 1'b1);
        stat.full       = (count_reg == MAX_CNT);
        stat.dn_more    = (j_reg < count_reg);
        stat.up_more    = (j_reg > p_reg);
        stat.list_last  = (idx_plus1 == count_reg);
        stat.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_high_reg, out_low_reg});
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `DIT_ASSERT(a_count_range, count_reg <= MAX_CNT, "interval count above table depth")
    `DIT_ASSERT(a_count_step, (count_reg == $past(count_reg)) || (count_reg == CNT_W'($past(count_reg) + 1'b1)) || (count_reg == CNT_W'($past(count_reg) - 1'b1)), "interval count moved by more than one")
    `DIT_ASSERT_IMP(a_load_free, load_out, !out_valid_reg || m_tready, "result register overwritten while held")

endmodule
